FILE: rtl/pulse_shape_discrimination_defines.svh
// Assertion helpers shared by the pulse shape discrimination RTL.
// Both expect clk and rst in the enclosing module.
`ifndef PULSE_SHAPE_DISCRIMINATION_DEFINES_SVH
`define PULSE_SHAPE_DISCRIMINATION_DEFINES_SVH

// property must hold on every clock edge outside reset
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence must hold whenever the trigger holds, same edge
`define PSD_ASSERT_IMP(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

FILE: rtl/psd_pkg.sv
package psd_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int BASE_W  = 16;
  localparam int PER_W   = 8;
  localparam int WIN_W   = 13;
  localparam int INT_W   = 38;
  localparam int Q_W     = 16;
  localparam int RATIO_W = Q_W + 1;

  localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
  localparam int LEN_W  = IDX_W + 1;
  localparam int CMP_W  = (LEN_W > WIN_W) ? LEN_W : WIN_W;
  localparam int DIFF_W = ((SAMPLE_BITS > BASE_W) ? SAMPLE_BITS : BASE_W) + 1;
  localparam int SUM_W  = DIFF_W + $clog2(MAX_SAMPLES) + 1;
  localparam int CNT_W  = $clog2(Q_W);

  // record queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register indexes of the write port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_BASELINE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FAST_START  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAST_END    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_START = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_END   = 3'd5;
  localparam int WDATA_W = 16;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [CMP_W-1:0]          cmp_t;
  typedef logic [WIN_W-1:0]          win_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [SUM_W-1:0]          mag_t;
  typedef logic signed [INT_W-1:0]   int_t;
  typedef logic [RATIO_W-1:0]        ratio_t;
  typedef logic [Q_W-1:0]            quo_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [PTR_W-1:0]          ptr_t;
  typedef logic [QCNT_W-1:0]         qcnt_t;

  localparam idx_t   MAX_IDX  = IDX_W'(MAX_SAMPLES);
  localparam len_t   MAX_LEN  = LEN_W'(MAX_SAMPLES);
  localparam ratio_t ONE_Q16  = ratio_t'(1) << Q_W;
  localparam cnt_t   LAST_CNT = CNT_W'(Q_W - 1);
  localparam qcnt_t  QFULL    = QCNT_W'(QDEPTH);
  localparam ptr_t   PTR_TOP  = PTR_W'(QDEPTH - 1);

  typedef struct packed {
    logic signed [BASE_W-1:0] baseline;
    logic [PER_W-1:0]         period;
    win_t                     fast_start;
    win_t                     fast_end;
    win_t                     total_start;
    win_t                     total_end;
  } cfg_t;

  // one finished waveform, handed from front to back
  typedef struct packed {
    sum_t fast_sum;
    sum_t total_sum;
    logic window_error;
  } record_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/psd_front.sv
`include "pulse_shape_discrimination_defines.svh"

module psd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  psd_pkg::cfg_t                       cfg,
  input  logic                                push,
  output logic                                full,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                last,
  input  logic                                q_full,
  output logic                                q_push,
  output psd_pkg::record_t                    q_data
);

  psd_pkg::idx_t  sample_index;
  psd_pkg::sum_t  fast_sum;
  psd_pkg::sum_t  total_sum;

  psd_pkg::diff_t d;
  psd_pkg::cmp_t  idx_c;
  psd_pkg::len_t  len;
  psd_pkg::cmp_t  len_c;
  logic           in_range;
  logic           in_fast;
  logic           in_total;
  logic           accept;
  logic           werr;
  psd_pkg::sum_t  fast_next;
  psd_pkg::sum_t  total_next;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && last;

  always_comb begin
    d = psd_pkg::diff_t'(signed'(sample[psd_pkg::SAMPLE_BITS-1:0]))
        - psd_pkg::diff_t'(cfg.baseline);
    idx_c    = psd_pkg::cmp_t'(sample_index);
    in_range = sample_index < psd_pkg::MAX_IDX;
    in_fast  = in_range && idx_c >= psd_pkg::cmp_t'(cfg.fast_start)
               && idx_c < psd_pkg::cmp_t'(cfg.fast_end);
    in_total = in_range && idx_c >= psd_pkg::cmp_t'(cfg.total_start)
               && idx_c < psd_pkg::cmp_t'(cfg.total_end);
    fast_next  = fast_sum + (in_fast ? psd_pkg::sum_t'(d) : '0);
    total_next = total_sum + (in_total ? psd_pkg::sum_t'(d) : '0);

    // record length; one past the limit flags an overlong record
    len   = psd_pkg::len_t'(sample_index) + psd_pkg::len_t'(1);
    len_c = psd_pkg::cmp_t'(len);
    werr  = len > psd_pkg::MAX_LEN
            || psd_pkg::cmp_t'(cfg.fast_start) > len_c
            || psd_pkg::cmp_t'(cfg.fast_end) > len_c
            || psd_pkg::cmp_t'(cfg.total_start) > len_c
            || psd_pkg::cmp_t'(cfg.total_end) > len_c;

    q_data.fast_sum     = fast_next;
    q_data.total_sum    = total_next;
    q_data.window_error = werr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      fast_sum     <= '0;
      total_sum    <= '0;
    end else if (accept) begin
      if (last) begin
        sample_index <= '0;
        fast_sum     <= '0;
        total_sum    <= '0;
      end else begin
        fast_sum  <= fast_next;
        total_sum <= total_next;
        if (in_range) begin
          sample_index <= sample_index + psd_pkg::idx_t'(1);
        end
      end
    end
  end

  `PSD_ASSERT(a_index_range, sample_index <= psd_pkg::MAX_IDX, "sample index past limit")
  `PSD_ASSERT_IMP(a_push_room, q_push, !q_full, "record pushed into full queue")

endmodule

FILE: rtl/psd_fifo.sv
`include "pulse_shape_discrimination_defines.svh"

module psd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psd_pkg::record_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output psd_pkg::record_t rdata
);

  psd_pkg::record_t mem [psd_pkg::QDEPTH];
  psd_pkg::ptr_t    wr_ptr;
  psd_pkg::ptr_t    rd_ptr;
  psd_pkg::qcnt_t   count;

  assign full  = count == psd_pkg::QFULL;
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == psd_pkg::PTR_TOP) ? '0 : wr_ptr + psd_pkg::ptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == psd_pkg::PTR_TOP) ? '0 : rd_ptr + psd_pkg::ptr_t'(1);
      end
      if (push && !pop) begin
        count <= count + psd_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - psd_pkg::qcnt_t'(1);
      end
    end
  end

  `PSD_ASSERT(a_count_range, count <= psd_pkg::QFULL, "queue count overflow")
  `PSD_ASSERT(a_no_pop_empty, !(pop && count == '0), "pop from empty queue")

endmodule

FILE: rtl/psd_back.sv
`include "pulse_shape_discrimination_defines.svh"

module psd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  psd_pkg::cfg_t           cfg,
  input  logic                    q_empty,
  input  psd_pkg::record_t        q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output psd_pkg::int_t           total_integral,
  output psd_pkg::int_t           fast_integral,
  output psd_pkg::ratio_t         fast_ratio,
  output logic                    ratio_invalid,
  output logic                    window_error
);

  psd_pkg::state_t  state;
  psd_pkg::state_t  state_next;

  psd_pkg::record_t rec;
  psd_pkg::int_t    ti;
  psd_pkg::int_t    fi;
  logic             invalid;
  logic             opposite;
  logic             sat;
  psd_pkg::mag_t    den;
  psd_pkg::mag_t    rem;
  psd_pkg::quo_t    quo;
  psd_pkg::cnt_t    cnt;
  logic             out_valid;

  psd_pkg::mag_t          num_c;
  psd_pkg::mag_t          den_c;
  logic [psd_pkg::SUM_W:0] rem2;
  logic [psd_pkg::SUM_W:0] den2;
  logic                   ge;
  logic                   load_out;
  psd_pkg::int_t          period_s;

  assign empty = !out_valid;

  always_comb begin
    num_c = rec.fast_sum[psd_pkg::SUM_W-1] ? psd_pkg::mag_t'(-rec.fast_sum)
                                           : psd_pkg::mag_t'(rec.fast_sum);
    den_c = rec.total_sum[psd_pkg::SUM_W-1] ? psd_pkg::mag_t'(-rec.total_sum)
                                            : psd_pkg::mag_t'(rec.total_sum);
    period_s = psd_pkg::int_t'(signed'({1'b0, cfg.period}));
    rem2 = {rem, 1'b0};
    den2 = {1'b0, den};
    ge   = rem2 >= den2;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      psd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = psd_pkg::ST_CALC;
        end
      end
      psd_pkg::ST_CALC: begin
        state_next = psd_pkg::ST_DIV;
      end
      psd_pkg::ST_DIV: begin
        if (cnt == '0) begin
          state_next = psd_pkg::ST_DONE;
        end
      end
      psd_pkg::ST_DONE: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = psd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec <= q_data;
    end
    if (state == psd_pkg::ST_CALC) begin
      ti       <= psd_pkg::int_t'(rec.total_sum) * period_s;
      fi       <= psd_pkg::int_t'(rec.fast_sum) * period_s;
      invalid  <= rec.total_sum == '0;
      opposite <= (rec.fast_sum < 0 && rec.total_sum > 0)
                  || (rec.fast_sum > 0 && rec.total_sum < 0);
      sat      <= num_c >= den_c;
      den      <= den_c;
      // saturated case: keep the divider quiet
      rem      <= (num_c >= den_c) ? '0 : num_c;
      quo      <= '0;
      cnt      <= psd_pkg::LAST_CNT;
    end
    // restoring division, one quotient bit per cycle
    if (state == psd_pkg::ST_DIV) begin
      rem <= ge ? psd_pkg::mag_t'(rem2 - den2) : psd_pkg::mag_t'(rem2);
      quo <= {quo[psd_pkg::Q_W-2:0], ge};
      cnt <= cnt - psd_pkg::cnt_t'(1);
    end
    if (load_out) begin
      total_integral <= ti;
      fast_integral  <= fi;
      ratio_invalid  <= invalid;
      window_error   <= rec.window_error;
      if (invalid || opposite) begin
        fast_ratio <= '0;
      end else if (sat) begin
        fast_ratio <= psd_pkg::ONE_Q16;
      end else begin
        fast_ratio <= psd_pkg::ratio_t'(quo);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `PSD_ASSERT_IMP(a_ratio_range, out_valid, fast_ratio <= psd_pkg::ONE_Q16, "ratio above one")
  `PSD_ASSERT_IMP(a_invalid_zero, out_valid && ratio_invalid, fast_ratio == '0, "invalid ratio not zero")

endmodule

FILE: rtl/pulse_shape_discrimination.sv
// Result path: once the last sample of a waveform is accepted, empty falls after record
// fetch, multiply, restoring divide and output load, when the back end is idle.
// Throughput: one sample per cycle while full is low. The back end takes one waveform at
// a time; short waveforms or an unread result fill the 2-entry queue and stall push.
// Reset (rst, synchronous, active high) restores the register defaults,
// clears sums, index, queue and the result valid flag.
module pulse_shape_discrimination (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  logic signed [psd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  output logic                                   empty,
  input  logic                                   pop,
  output logic signed [psd_pkg::INT_W-1:0]       total_integral,
  output logic signed [psd_pkg::INT_W-1:0]       fast_integral,
  output logic [psd_pkg::RATIO_W-1:0]            fast_ratio,
  output logic                                   ratio_invalid,
  output logic                                   window_error,
  input  logic                                   wr_en,
  input  logic [psd_pkg::REG_IDX_W-1:0]          wr_index,
  input  logic [psd_pkg::WDATA_W-1:0]            wr_data
);

  psd_pkg::cfg_t    cfg;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  psd_pkg::record_t q_wdata;
  psd_pkg::record_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.baseline    <= '0;
      cfg.period      <= psd_pkg::PER_W'(4);
      cfg.fast_start  <= psd_pkg::WIN_W'(450);
      cfg.fast_end    <= psd_pkg::WIN_W'(550);
      cfg.total_start <= psd_pkg::WIN_W'(450);
      cfg.total_end   <= psd_pkg::WIN_W'(1975);
    end else if (wr_en) begin
      unique case (wr_index)
        psd_pkg::REG_BASELINE:    cfg.baseline    <= signed'(wr_data[psd_pkg::BASE_W-1:0]);
        psd_pkg::REG_PERIOD:      cfg.period      <= wr_data[psd_pkg::PER_W-1:0];
        psd_pkg::REG_FAST_START:  cfg.fast_start  <= wr_data[psd_pkg::WIN_W-1:0];
        psd_pkg::REG_FAST_END:    cfg.fast_end    <= wr_data[psd_pkg::WIN_W-1:0];
        psd_pkg::REG_TOTAL_START: cfg.total_start <= wr_data[psd_pkg::WIN_W-1:0];
        psd_pkg::REG_TOTAL_END:   cfg.total_end   <= wr_data[psd_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  psd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .sample (sample),
    .last   (last),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  psd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  psd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .total_integral (total_integral),
    .fast_integral  (fast_integral),
    .fast_ratio     (fast_ratio),
    .ratio_invalid  (ratio_invalid),
    .window_error   (window_error)
  );

endmodule
